>>> rtl/core/hid_keyboard_line_assembler_defines.svh
// Assertion macros shared by the line assembler RTL.
// Each use expands to one named concurrent assertion clocked on clk and
// disabled while arst_n is low.
`ifndef HID_KEYBOARD_LINE_ASSEMBLER_DEFINES_SVH
`define HID_KEYBOARD_LINE_ASSEMBLER_DEFINES_SVH

`ifndef SYNTHESIS
`define HKLA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("hkla assertion failed");
`define HKLA_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("hkla forbidden condition seen");
`else
`define HKLA_ASSERT(lbl, prop)
`define HKLA_NEVER(lbl, cond)
`endif

`endif

>>> rtl/core/hkla_pkg.sv
package hkla_pkg;

	// Report and line geometry
	localparam int KEY_SLOTS = 6;
	localparam int SLOT_W    = $clog2(KEY_SLOTS);
	localparam int LINE_CAP  = 31;
	localparam int LEN_W     = $clog2(LINE_CAP + 1);
	localparam int IDX_W     = $clog2(LINE_CAP);

	localparam logic [LEN_W-1:0]  LINE_CAP_L = LEN_W'(LINE_CAP);
	localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(KEY_SLOTS - 1);

	// HID usage codes and character codes
	localparam logic [7:0] NO_KEY_LIMIT = 8'd3;
	localparam logic [7:0] LAST_KEY     = 8'd56;
	localparam logic [7:0] SHIFT_MASK   = 8'h22;
	localparam logic [6:0] CH_CR        = 7'd13;
	localparam logic [6:0] CH_LF        = 7'd10;

	typedef logic [7:0] key_code_t;
	typedef key_code_t [KEY_SLOTS-1:0] key_set_t;

	// What one lane found for its slot
	typedef struct packed {
		logic       hit;
		logic [6:0] ch;
	} lane_res_t;

	typedef lane_res_t [KEY_SLOTS-1:0] lane_set_t;

	// Boot keyboard usage code to ASCII; zero where no character exists
	function automatic logic [6:0] key_to_ascii(input logic [7:0] code, input logic shift);
		logic [6:0] c;
		c = 7'd0;
		if (code >= 8'd4 && code <= 8'd29) begin
			c = shift ? 7'(code + 8'd61) : 7'(code + 8'd93);
		end else begin
			unique case (code)
				8'd30: c = shift ? 7'h21 : 7'h31;
				8'd31: c = shift ? 7'h40 : 7'h32;
				8'd32: c = shift ? 7'h23 : 7'h33;
				8'd33: c = shift ? 7'h24 : 7'h34;
				8'd34: c = shift ? 7'h25 : 7'h35;
				8'd35: c = shift ? 7'h5E : 7'h36;
				8'd36: c = shift ? 7'h26 : 7'h37;
				8'd37: c = shift ? 7'h2A : 7'h38;
				8'd38: c = shift ? 7'h28 : 7'h39;
				8'd39: c = shift ? 7'h29 : 7'h30;
				8'd40: c = CH_CR;
				8'd42: c = shift ? 7'h00 : 7'h08;
				8'd44: c = 7'h20;
				8'd45: c = shift ? 7'h5F : 7'h2D;
				8'd46: c = shift ? 7'h2B : 7'h3D;
				8'd47: c = shift ? 7'h7B : 7'h5B;
				8'd48: c = shift ? 7'h7D : 7'h5D;
				8'd49: c = shift ? 7'h7C : 7'h5C;
				8'd50: c = shift ? 7'h7C : 7'h5C;
				8'd51: c = shift ? 7'h3A : 7'h3B;
				8'd52: c = shift ? 7'h22 : 7'h27;
				8'd53: c = shift ? 7'h7E : 7'h60;
				8'd54: c = shift ? 7'h3C : 7'h2C;
				8'd55: c = shift ? 7'h3E : 7'h2E;
				8'd56: c = shift ? 7'h3F : 7'h2F;
				default: c = 7'd0;
			endcase
		end
		return c;
	endfunction

endpackage

>>> rtl/core/hkla_if.sv
// Report channel: one boot keyboard report per transfer
interface hkla_report_if;
	logic       valid;
	logic       ready;
	logic       report_complete;
	logic [7:0] modifier_bits;
	logic [7:0] key_slot_0;
	logic [7:0] key_slot_1;
	logic [7:0] key_slot_2;
	logic [7:0] key_slot_3;
	logic [7:0] key_slot_4;
	logic [7:0] key_slot_5;

	modport source (
		output valid, report_complete, modifier_bits,
		output key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
		input  ready
	);
	modport sink (
		input  valid, report_complete, modifier_bits,
		input  key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
		output ready
	);
endinterface

// Character channel: one character of a finished line per transfer
interface hkla_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] uid_char;
	logic [4:0] uid_position;
	logic       line_end;

	modport source (
		output valid, uid_char, uid_position, line_end,
		input  ready
	);
	modport sink (
		input  valid, uid_char, uid_position, line_end,
		output ready
	);
endinterface

>>> rtl/core/hkla_lane.sv
// One slot: new-press detection against the previous report and ASCII lookup
module hkla_lane (
	input  hkla_pkg::key_code_t code,
	input  logic                shift,
	input  hkla_pkg::key_set_t  held,
	output hkla_pkg::lane_res_t result
);

	logic       was_held;
	logic [6:0] ch;

	// Compare against every key of the previous report
	always_comb begin
		was_held = 1'b0;
		for (int i = 0; i < hkla_pkg::KEY_SLOTS; i++) begin
			if (held[i] == code) was_held = 1'b1;
		end
	end

	assign ch = hkla_pkg::key_to_ascii(code, shift);

	// A press counts only when new, mapped and nonzero
	assign result.ch  = ch;
	assign result.hit = (code > hkla_pkg::NO_KEY_LIMIT) && (code <= hkla_pkg::LAST_KEY) &&
		!was_held && (ch != 7'd0);

endmodule

>>> rtl/core/hkla_merge.sv
`include "hid_keyboard_line_assembler_defines.svh"

// Walks the lane results in slot order, builds the line and flushes it
module hkla_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  hkla_pkg::lane_set_t lanes,
	output logic                busy,
	hkla_char_if.source         chars
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]                    state_q;
	logic [hkla_pkg::SLOT_W-1:0]   slot_q;
	logic [hkla_pkg::LEN_W-1:0]    len_q;
	logic [hkla_pkg::IDX_W-1:0]    rd_q;
	logic                          out_valid_q;
	logic [6:0]                    out_char_q;
	logic [4:0]                    out_pos_q;
	logic                          out_end_q;
	hkla_pkg::lane_set_t           lane_s1;
	logic [6:0]                    line_q [hkla_pkg::LINE_CAP];

	hkla_pkg::lane_res_t cur;
	logic                is_eol;
	logic                flush_go;
	logic                append;
	logic                last_slot;
	logic                rd_is_last;
	logic                emit;

	// Current slot decode
	assign cur        = lane_s1[slot_q];
	assign is_eol     = (cur.ch == hkla_pkg::CH_CR) || (cur.ch == hkla_pkg::CH_LF);
	assign flush_go   = cur.hit && is_eol && (len_q != '0);
	assign append     = cur.hit && !is_eol && (len_q < hkla_pkg::LINE_CAP_L);
	assign last_slot  = (slot_q == hkla_pkg::LAST_SLOT);
	assign rd_is_last = (hkla_pkg::LEN_W'(rd_q) == len_q - hkla_pkg::LEN_W'(1));
	assign emit       = (state_q == ST_FLUSH) && (!out_valid_q || chars.ready);
	assign busy       = (state_q != ST_IDLE);

	// Sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			len_q       <= '0;
			rd_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) out_valid_q <= 1'b1;
			else if (chars.ready) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_WALK;
						slot_q  <= '0;
					end
				end
				ST_WALK: begin
					if (flush_go) begin
						state_q <= ST_FLUSH;
						rd_q    <= '0;
					end else begin
						if (append) len_q <= len_q + hkla_pkg::LEN_W'(1);
						if (last_slot) state_q <= ST_IDLE;
						else slot_q <= slot_q + hkla_pkg::SLOT_W'(1);
					end
				end
				ST_FLUSH: begin
					if (emit) begin
						if (rd_is_last) begin
							len_q <= '0;
							if (last_slot) begin
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_WALK;
								slot_q  <= slot_q + hkla_pkg::SLOT_W'(1);
							end
						end else begin
							rd_q <= rd_q + hkla_pkg::IDX_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Lane results, line store and output payload
	always_ff @(posedge clk) begin
		if (start && state_q == ST_IDLE) lane_s1 <= lanes;
		if (state_q == ST_WALK && !flush_go && append) begin
			line_q[len_q[hkla_pkg::IDX_W-1:0]] <= cur.ch;
		end
		if (emit) begin
			out_char_q <= line_q[rd_q];
			out_pos_q  <= 5'(rd_q);
			out_end_q  <= rd_is_last;
		end
	end

	assign chars.valid        = out_valid_q;
	assign chars.uid_char     = out_char_q;
	assign chars.uid_position = out_pos_q;
	assign chars.line_end     = out_end_q;

	`HKLA_ASSERT(a_len_cap, len_q <= hkla_pkg::LINE_CAP_L)
	`HKLA_ASSERT(a_flush_in_range, (state_q == ST_FLUSH) |-> (len_q != '0 && hkla_pkg::LEN_W'(rd_q) < len_q))
	`HKLA_NEVER(a_start_while_busy, start && (state_q != ST_IDLE))
	`HKLA_ASSERT(a_last_empties, (emit && rd_is_last) |=> (len_q == '0 && out_valid_q && out_end_q))

endmodule

>>> rtl/core/hid_keyboard_line_assembler.sv
// Turns boot keyboard reports into text lines. Each report on keys is one
// transfer; six lanes check the six key slots in parallel against the keys of
// the previous complete report and look up the ASCII code, then a merge stage
// walks the slots in order, appending characters to a 31-character line and,
// on Enter, sending the buffered line on chars one character per transfer
// with line_end on the last. An accepted report is registered, its lane
// results are registered into the merge stage, and the merge walks the key
// slots, waiting on each flushed character while chars is not ready; a
// single report can send at most 35 characters. keys is ready again once the
// walk ends, even while the last character still waits in the output
// register. Incomplete reports are taken and ignored.
module hid_keyboard_line_assembler (
	input  logic          clk,
	input  logic          arst_n,
	hkla_report_if.sink   keys,
	hkla_char_if.source   chars
);

	logic                 pend_q;
	logic                 shift_q;
	hkla_pkg::key_set_t   cur_q;
	hkla_pkg::key_set_t   prev_q;
	hkla_pkg::lane_set_t  lane_res;
	logic                 busy;
	logic                 take;

	assign keys.ready = !pend_q && !busy;
	assign take       = keys.valid && keys.ready && keys.report_complete;

	// Report capture and previous-key history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			prev_q <= '0;
		end else begin
			if (take) pend_q <= 1'b1;
			else if (pend_q) pend_q <= 1'b0;
			if (pend_q) prev_q <= cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			shift_q  <= |(keys.modifier_bits & hkla_pkg::SHIFT_MASK);
			cur_q[0] <= keys.key_slot_0;
			cur_q[1] <= keys.key_slot_1;
			cur_q[2] <= keys.key_slot_2;
			cur_q[3] <= keys.key_slot_3;
			cur_q[4] <= keys.key_slot_4;
			cur_q[5] <= keys.key_slot_5;
		end
	end

	// One lane per key slot
	for (genvar g = 0; g < hkla_pkg::KEY_SLOTS; g++) begin : g_lane
		hkla_lane u_lane (
			.code   (cur_q[g]),
			.shift  (shift_q),
			.held   (prev_q),
			.result (lane_res[g])
		);
	end

	hkla_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pend_q),
		.lanes  (lane_res),
		.busy   (busy),
		.chars  (chars)
	);

endmodule
